FILE: rtl/spm_pkg.sv
// Package for the slotted page manager: transaction payload types, request and
// status codes, and the command and status types between controller and datapath.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package spm_pkg;

  localparam int AXW = 18;

  localparam logic [2:0] REQ_ADD    = 3'd0;
  localparam logic [2:0] REQ_GET    = 3'd1;
  localparam logic [2:0] REQ_RESIZE = 3'd2;
  localparam logic [2:0] REQ_DELETE = 3'd3;
  localparam logic [2:0] REQ_WRITE  = 3'd4;
  localparam logic [2:0] REQ_READ   = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_ROOM = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;

  localparam logic [9:0] MAX_COUNT = 10'd1023;

  localparam logic [4:0] C_NOP      = 5'd0;
  localparam logic [4:0] C_LOAD     = 5'd1;
  localparam logic [4:0] C_HDR      = 5'd2;
  localparam logic [4:0] C_ADD_UPD  = 5'd3;
  localparam logic [4:0] C_ENT_WR   = 5'd4;
  localparam logic [4:0] C_ENT_RD   = 5'd5;
  localparam logic [4:0] C_ENT_LAST = 5'd6;
  localparam logic [4:0] C_RSZ_PREP = 5'd7;
  localparam logic [4:0] C_DEL_PREP = 5'd8;
  localparam logic [4:0] C_SH_SETUP = 5'd9;
  localparam logic [4:0] C_CP_RD    = 5'd10;
  localparam logic [4:0] C_CP_WR    = 5'd11;
  localparam logic [4:0] C_WALK_INIT = 5'd12;
  localparam logic [4:0] C_WK_RD    = 5'd13;
  localparam logic [4:0] C_WK_WR    = 5'd14;
  localparam logic [4:0] C_WK_NEXT  = 5'd15;
  localparam logic [4:0] C_FE_UPD   = 5'd16;
  localparam logic [4:0] C_MEM_WR   = 5'd17;
  localparam logic [4:0] C_MEM_RD   = 5'd18;
  localparam logic [4:0] C_FIN      = 5'd19;

  localparam logic [3:0] K_ERR      = 4'd0;
  localparam logic [3:0] K_NO_ROOM  = 4'd1;
  localparam logic [3:0] K_ADD_OK   = 4'd2;
  localparam logic [3:0] K_GET_OK   = 4'd3;
  localparam logic [3:0] K_RSZ_FAIL = 4'd4;
  localparam logic [3:0] K_RSZ_OK   = 4'd5;
  localparam logic [3:0] K_DEL_OK   = 4'd6;
  localparam logic [3:0] K_WR_OK    = 4'd7;
  localparam logic [3:0] K_RD_OK    = 4'd8;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [9:0]  rec_id;
    logic [11:0] length;
    logic [11:0] offset;
    logic [7:0]  wdata;
  } spm_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  slot;
    logic [11:0] location;
    logic [11:0] size_out;
    logic [7:0]  rdata;
  } spm_out_t;

  typedef struct packed {
    logic [4:0] op;
    logic [1:0] idx;
    logic [3:0] kind;
  } spm_cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       id_ok;
    logic       add_ok;
    logic       grow;
    logic       grow_ok;
    logic       sane;
    logic       lc_zero;
    logic       off_ok;
    logic       move_zero;
    logic       rem_zero;
    logic       rem_last;
    logic       k_over;
    logic       hit;
  } spm_stat_t;

endpackage
`default_nettype wire

FILE: rtl/spm_ctrl.sv
// Controller state machine of the slotted page manager.
// Sequences datapath commands; depends on spm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire spm_pkg::spm_stat_t st,
  output spm_pkg::spm_cmd_t      cmd
);
  import spm_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_HDR   = 5'd1;
  localparam logic [4:0] S_DISP  = 5'd2;
  localparam logic [4:0] S_FIN   = 5'd3;
  localparam logic [4:0] S_AWR   = 5'd4;
  localparam logic [4:0] S_ERD   = 5'd5;
  localparam logic [4:0] S_ELAST = 5'd6;
  localparam logic [4:0] S_ECHK  = 5'd7;
  localparam logic [4:0] S_DWR   = 5'd8;
  localparam logic [4:0] S_SH0   = 5'd9;
  localparam logic [4:0] S_SH1   = 5'd10;
  localparam logic [4:0] S_CPR   = 5'd11;
  localparam logic [4:0] S_CPW   = 5'd12;
  localparam logic [4:0] S_WKI   = 5'd13;
  localparam logic [4:0] S_WK    = 5'd14;
  localparam logic [4:0] S_WK1   = 5'd15;
  localparam logic [4:0] S_WK2   = 5'd16;
  localparam logic [4:0] S_WK3   = 5'd17;
  localparam logic [4:0] S_WK4   = 5'd18;
  localparam logic [4:0] S_POST  = 5'd19;
  localparam logic [4:0] S_RWR   = 5'd20;

  logic [4:0] state_r, state_nxt;
  logic [4:0] ret_r, ret_nxt;
  logic [3:0] fin_r, fin_nxt;
  logic [1:0] j_r, j_nxt;
  logic       phase_r, phase_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    fin_nxt       = fin_r;
    j_nxt         = j_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '{op: C_NOP, idx: 2'd0, kind: K_ERR};
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = C_LOAD;
          phase_nxt = 1'b0;
          state_nxt = S_DISP;
        end
      end
      S_HDR: begin
        cmd.op  = C_HDR;
        cmd.idx = j_r;
        j_nxt   = j_r + 2'd1;
        if (j_r == 2'd3) begin
          state_nxt = ret_r;
        end
      end
      S_DISP: begin
        state_nxt = S_FIN;
        fin_nxt   = K_ERR;
        case (st.req_type)
          REQ_ADD: begin
            if (st.add_ok) begin
              cmd.op    = C_ADD_UPD;
              j_nxt     = 2'd0;
              state_nxt = S_AWR;
            end else begin
              fin_nxt = K_NO_ROOM;
            end
          end
          REQ_GET, REQ_RESIZE, REQ_DELETE: begin
            if (st.id_ok) begin
              j_nxt     = 2'd0;
              state_nxt = S_ERD;
            end
          end
          REQ_WRITE: begin
            if (st.off_ok) begin
              cmd.op  = C_MEM_WR;
              fin_nxt = K_WR_OK;
            end
          end
          REQ_READ: begin
            if (st.off_ok) begin
              cmd.op  = C_MEM_RD;
              fin_nxt = K_RD_OK;
            end
          end
          default: begin
            fin_nxt = K_ERR;
          end
        endcase
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = C_FIN;
          cmd.kind      = fin_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_AWR: begin
        cmd.op  = C_ENT_WR;
        cmd.idx = j_r;
        j_nxt   = j_r + 2'd1;
        if (j_r == 2'd3) begin
          ret_nxt   = S_FIN;
          fin_nxt   = K_ADD_OK;
          state_nxt = S_HDR;
        end
      end
      S_ERD: begin
        cmd.op  = C_ENT_RD;
        cmd.idx = j_r;
        j_nxt   = j_r + 2'd1;
        if (j_r == 2'd3) begin
          state_nxt = S_ELAST;
        end
      end
      S_ELAST: begin
        cmd.op    = C_ENT_LAST;
        cmd.idx   = 2'd3;
        j_nxt     = 2'd0;
        state_nxt = phase_r ? S_RWR : S_ECHK;
      end
      S_ECHK: begin
        state_nxt = S_FIN;
        fin_nxt   = K_ERR;
        case (st.req_type)
          REQ_GET: begin
            if (!st.lc_zero) begin
              fin_nxt = K_GET_OK;
            end
          end
          REQ_RESIZE: begin
            if (st.sane) begin
              if (st.grow && !st.grow_ok) begin
                fin_nxt = K_RSZ_FAIL;
              end else begin
                cmd.op    = C_RSZ_PREP;
                state_nxt = S_SH0;
              end
            end
          end
          default: begin
            if (st.sane) begin
              cmd.op    = C_DEL_PREP;
              j_nxt     = 2'd0;
              state_nxt = S_DWR;
            end
          end
        endcase
      end
      S_DWR: begin
        cmd.op  = C_ENT_WR;
        cmd.idx = j_r;
        j_nxt   = j_r + 2'd1;
        if (j_r == 2'd3) begin
          state_nxt = S_SH0;
        end
      end
      S_SH0: begin
        cmd.op    = C_SH_SETUP;
        state_nxt = S_SH1;
      end
      S_SH1: begin
        if (st.move_zero) begin
          state_nxt = S_POST;
        end else if (st.rem_zero) begin
          state_nxt = S_WKI;
        end else begin
          state_nxt = S_CPR;
        end
      end
      S_CPR: begin
        cmd.op    = C_CP_RD;
        state_nxt = S_CPW;
      end
      S_CPW: begin
        cmd.op    = C_CP_WR;
        state_nxt = st.rem_last ? S_WKI : S_CPR;
      end
      S_WKI: begin
        cmd.op    = C_WALK_INIT;
        state_nxt = S_WK;
      end
      S_WK: begin
        if (st.k_over) begin
          cmd.op    = C_FE_UPD;
          ret_nxt   = S_POST;
          j_nxt     = 2'd0;
          state_nxt = S_HDR;
        end else begin
          cmd.op    = C_WK_RD;
          cmd.idx   = 2'd0;
          state_nxt = S_WK1;
        end
      end
      S_WK1: begin
        cmd.op    = C_WK_RD;
        cmd.idx   = 2'd1;
        state_nxt = S_WK2;
      end
      S_WK2: begin
        cmd.op    = C_WK_RD;
        cmd.idx   = 2'd2;
        state_nxt = S_WK3;
      end
      S_WK3: begin
        if (st.hit) begin
          cmd.op    = C_WK_WR;
          cmd.idx   = 2'd0;
          state_nxt = S_WK4;
        end else begin
          cmd.op    = C_WK_NEXT;
          state_nxt = S_WK;
        end
      end
      S_WK4: begin
        cmd.op    = C_WK_WR;
        cmd.idx   = 2'd1;
        state_nxt = S_WK;
      end
      S_POST: begin
        if (st.req_type == REQ_RESIZE) begin
          phase_nxt = 1'b1;
          j_nxt     = 2'd0;
          state_nxt = S_ERD;
        end else begin
          fin_nxt   = K_DEL_OK;
          state_nxt = S_FIN;
        end
      end
      S_RWR: begin
        cmd.op  = C_ENT_WR;
        cmd.idx = j_r;
        j_nxt   = j_r + 2'd1;
        if (j_r == 2'd1) begin
          phase_nxt = 1'b0;
          fin_nxt   = K_RSZ_OK;
          state_nxt = S_FIN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_HDR;
      ret_r       <= S_IDLE;
      fin_r       <= K_ERR;
      j_r         <= 2'd0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      fin_r       <= fin_nxt;
      j_r         <= j_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_fin_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == C_FIN) |-> (!out_valid_r || out_ready))
    else $error("Result loaded while the output register was still occupied.");
  a_fin_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == C_FIN) |=> out_valid_r)
    else $error("Result loaded without raising out_valid.");
  a_ready_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && !in_valid) |-> (cmd.op == C_NOP))
    else $error("Command issued while waiting for a transaction.");
`endif

endmodule
`default_nettype wire

FILE: rtl/spm_dp.sv
// Datapath of the slotted page manager: page memory, page registers and the
// pointers used to slide record bodies and walk the directory. Depends on spm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spm_dp #(
  parameter int PAGE_BYTES = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire spm_pkg::spm_in_t  in_data,
  input  wire spm_pkg::spm_cmd_t cmd,
  output spm_pkg::spm_stat_t     st,
  output spm_pkg::spm_out_t      out_data
);
  import spm_pkg::*;

  localparam int AW = $clog2(PAGE_BYTES);
  localparam logic [AXW-1:0] PAGE_X = AXW'(PAGE_BYTES);

  logic [7:0]     mem [PAGE_BYTES];
  logic [7:0]     mem_q_r;
  logic           mem_we, mem_re;
  logic [AXW-1:0] mem_wa, mem_ra;
  logic [7:0]     mem_wd;

  spm_in_t        req_r;
  spm_out_t       out_r, out_nxt;
  logic [9:0]     cnt_r;
  logic [AW-1:0]  fe_r;
  logic [11:0]    base_r;
  logic [15:0]    sz_r, lc_r, ent_sz_r, ent_lc_r, wlc_r;
  logic [AXW-1:0] start_r, end_r, move_r, src_r, dst_r, rem_r;
  logic [10:0]    k_r;

  logic [AXW-1:0] fe_x, dir_top, need_add, need_grow, lo_w, n_w, base_a, wk_a, mv_w;
  logic [11:0]    d_w;
  logic [15:0]    wlc_new, fe16;
  logic [31:0]    hdr_w, ent_w;
  logic           move_pos;

  assign fe_x      = AXW'(fe_r);
  assign fe16      = 16'(fe_r);
  assign dir_top   = AXW'({cnt_r, 2'b00}) + AXW'(4);
  assign need_add  = dir_top + AXW'(req_r.length);
  assign d_w       = req_r.length - sz_r[11:0];
  assign need_grow = dir_top + AXW'(d_w);
  assign lo_w      = fe_x + AXW'(1);
  assign n_w       = start_r - lo_w;
  assign mv_w      = end_r - start_r;
  assign move_pos  = !move_r[AXW-1] && (move_r != '0);
  assign base_a    = AXW'(base_r) + AXW'(cmd.idx);
  assign wk_a      = AXW'({k_r, 2'b10}) + AXW'(cmd.idx);
  assign wlc_new   = wlc_r + move_r[15:0];
  assign hdr_w     = {fe16, 6'd0, cnt_r};
  assign ent_w     = {ent_lc_r, ent_sz_r};

  always_comb begin
    st.req_type  = req_r.req_type;
    st.id_ok     = (req_r.rec_id != 10'd0) && (req_r.rec_id <= cnt_r);
    st.add_ok    = (cnt_r != MAX_COUNT) && (fe_x >= need_add);
    st.grow      = {4'd0, req_r.length} > sz_r;
    st.grow_ok   = fe_x >= need_grow;
    st.sane      = (lc_r != 16'd0) && (AXW'(lc_r) > fe_x) &&
                   ((AXW'(lc_r) + AXW'(sz_r)) <= PAGE_X);
    st.lc_zero   = lc_r == 16'd0;
    st.off_ok    = AXW'(req_r.offset) < PAGE_X;
    st.move_zero = move_r == '0;
    st.rem_zero  = rem_r == '0;
    st.rem_last  = rem_r == AXW'(1);
    st.k_over    = k_r > {1'b0, cnt_r};
    st.hit       = (wlc_r != 16'd0) && (AXW'(wlc_r) <= start_r);
  end

  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_wa = '0;
    mem_ra = '0;
    mem_wd = '0;
    case (cmd.op)
      C_HDR: begin
        mem_we = 1'b1;
        mem_wa = AXW'(cmd.idx);
        mem_wd = hdr_w[{cmd.idx, 3'b000} +: 8];
      end
      C_ENT_WR: begin
        mem_wa = base_a;
        mem_we = base_a < PAGE_X;
        mem_wd = ent_w[{cmd.idx, 3'b000} +: 8];
      end
      C_ENT_RD: begin
        mem_re = 1'b1;
        mem_ra = base_a;
      end
      C_CP_RD: begin
        mem_re = 1'b1;
        mem_ra = src_r;
      end
      C_CP_WR: begin
        mem_wa = dst_r;
        mem_we = dst_r < PAGE_X;
        mem_wd = mem_q_r;
      end
      C_WK_RD: begin
        mem_re = cmd.idx != 2'd2;
        mem_ra = wk_a;
      end
      C_WK_WR: begin
        mem_wa = wk_a;
        mem_we = wk_a < PAGE_X;
        mem_wd = cmd.idx[0] ? wlc_new[15:8] : wlc_new[7:0];
      end
      C_MEM_WR: begin
        mem_we = 1'b1;
        mem_wa = AXW'(req_r.offset);
        mem_wd = req_r.wdata;
      end
      C_MEM_RD: begin
        mem_re = 1'b1;
        mem_ra = AXW'(req_r.offset);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa[AW-1:0]] <= mem_wd;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_ra[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      fe_r  <= AW'(PAGE_BYTES - 1);
    end else begin
      case (cmd.op)
        C_ADD_UPD: begin
          cnt_r <= cnt_r + 10'd1;
          fe_r  <= fe_r - AW'(req_r.length);
        end
        C_FE_UPD: begin
          fe_r <= AW'(fe_x + move_r);
        end
        default: begin
          cnt_r <= cnt_r;
        end
      endcase
    end
  end

  always_comb begin
    out_nxt        = '0;
    out_nxt.status = ST_OK;
    out_nxt.slot   = req_r.rec_id;
    case (cmd.kind)
      K_NO_ROOM: begin
        out_nxt.status = ST_NO_ROOM;
        out_nxt.slot   = '0;
      end
      K_ADD_OK: begin
        out_nxt.slot     = cnt_r;
        out_nxt.location = ent_lc_r[11:0];
        out_nxt.size_out = req_r.length;
      end
      K_GET_OK: begin
        out_nxt.location = lc_r[11:0];
        out_nxt.size_out = sz_r[11:0];
      end
      K_RSZ_FAIL: begin
        out_nxt.status   = ST_NO_ROOM;
        out_nxt.location = lc_r[11:0];
        out_nxt.size_out = sz_r[11:0];
      end
      K_RSZ_OK: begin
        out_nxt.location = lc_r[11:0];
        out_nxt.size_out = req_r.length;
      end
      K_DEL_OK, K_WR_OK: begin
        out_nxt.status = ST_OK;
      end
      K_RD_OK: begin
        out_nxt.rdata = mem_q_r;
      end
      default: begin
        out_nxt.status = ST_ABSENT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      C_LOAD: begin
        req_r  <= in_data;
        base_r <= {in_data.rec_id, 2'b00};
      end
      C_ADD_UPD: begin
        base_r   <= dir_top[11:0];
        ent_sz_r <= 16'(req_r.length);
        ent_lc_r <= 16'(fe_x - AXW'(req_r.length) + AXW'(1));
      end
      C_ENT_RD: begin
        case (cmd.idx)
          2'd1: sz_r[7:0]  <= mem_q_r;
          2'd2: sz_r[15:8] <= mem_q_r;
          2'd3: lc_r[7:0]  <= mem_q_r;
          default: lc_r <= lc_r;
        endcase
      end
      C_ENT_LAST: begin
        lc_r[15:8] <= mem_q_r;
      end
      C_RSZ_PREP: begin
        ent_sz_r <= 16'(req_r.length);
        if (st.grow) begin
          start_r <= AXW'(lc_r);
          end_r   <= AXW'(lc_r) - AXW'(d_w);
        end else begin
          start_r <= AXW'(lc_r) + AXW'(req_r.length);
          end_r   <= AXW'(lc_r) + AXW'(sz_r);
        end
      end
      C_DEL_PREP: begin
        ent_sz_r <= '0;
        ent_lc_r <= '0;
        start_r  <= AXW'(lc_r);
        end_r    <= AXW'(lc_r) + AXW'(sz_r);
      end
      C_SH_SETUP: begin
        move_r <= mv_w;
        rem_r  <= (!n_w[AXW-1]) ? n_w : '0;
        if (!mv_w[AXW-1]) begin
          src_r <= start_r - AXW'(1);
          dst_r <= end_r - AXW'(1);
        end else begin
          src_r <= lo_w;
          dst_r <= lo_w + mv_w;
        end
      end
      C_CP_WR: begin
        rem_r <= rem_r - AXW'(1);
        if (move_pos) begin
          src_r <= src_r - AXW'(1);
          dst_r <= dst_r - AXW'(1);
        end else begin
          src_r <= src_r + AXW'(1);
          dst_r <= dst_r + AXW'(1);
        end
      end
      C_WALK_INIT: begin
        k_r <= 11'd1;
      end
      C_WK_RD: begin
        if (cmd.idx == 2'd1) begin
          wlc_r[7:0] <= mem_q_r;
        end else if (cmd.idx == 2'd2) begin
          wlc_r[15:8] <= mem_q_r;
        end
      end
      C_WK_WR: begin
        if (cmd.idx[0]) begin
          k_r <= k_r + 11'd1;
        end
      end
      C_WK_NEXT: begin
        k_r <= k_r + 11'd1;
      end
      C_FIN: begin
        out_r <= out_nxt;
      end
      default: begin
        k_r <= k_r;
      end
    endcase
  end

  assign out_data = out_r;

`ifndef NO_ASSERTIONS
  a_add_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == C_ADD_UPD) |=> (cnt_r == $past(cnt_r) + 10'd1))
    else $error("Add did not advance the record count.");
  a_copy_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == C_CP_WR) |-> (rem_r != '0))
    else $error("Body copy beyond the region being moved.");
  a_walk_in_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == C_WK_WR) |-> (k_r <= {1'b0, cnt_r}) && (k_r != 11'd0))
    else $error("Directory update outside the live entries.");
`endif

endmodule
`default_nettype wire

FILE: rtl/slotted_page_manager_top.sv
// Top level of the slotted page manager: joins the controller and the datapath.
// Depends on spm_pkg, spm_ctrl and spm_dp.
`timescale 1ns / 1ps
`default_nettype none
// One slotted page of PAGE_BYTES bytes in a single-port byte memory, one read or
// one write per cycle. After reset the header is written before the first
// transaction is taken. A byte write or read and any request rejected on its
// fields go straight to the result; get, and requests rejected after the entry is
// read, first read the directory entry; add writes the new entry and then the
// header. Delete and resize rewrite the header, slide record body bytes with one
// read and one write each, and walk the directory entries, updating those whose
// bodies moved; a resize to the same length slides nothing and walks no entries.
// One request is handled at a time; a finished result waits in the output register
// while the next request is accepted.
module slotted_page_manager_top #(
  parameter int PAGE_BYTES = 4096
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire spm_pkg::spm_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output spm_pkg::spm_out_t     out_data
);
  import spm_pkg::*;

  spm_cmd_t  cmd;
  spm_stat_t st;

  spm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  spm_dp #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .st       (st),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
